// ===== hw/rtl/fifo_queue_with_search_top_macros.svh =====
// Assertion macros for the queue RTL.
// Depends on nothing; expects signals named clk and rst_n at the point of use.
`ifndef FIFO_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fq_pkg.sv =====
// Shared types, constants and helper functions for the searchable queue.
// Depends on nothing; used by the sequencer and the top level.
package fq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 64;
    localparam int DATA_BITS = 64;
    localparam int FILL_BITS = 5;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [DATA_BITS-1:0]   data_out;
        logic                   found;
        logic [FILL_BITS-1:0]   fill_count;
    } result_t;

    // Ring increment that wraps at DEPTH, also for depths that are no power of two.
    function automatic logic [ADDR_BITS-1:0] next_slot(input logic [ADDR_BITS-1:0] idx);
        logic [ADDR_BITS-1:0] res;
        if (idx == ADDR_BITS'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + ADDR_BITS'(1);
        end
        return res;
    endfunction

    // Count as shown in the five-bit result field: low bits only.
    function automatic logic [FILL_BITS-1:0] fill_field(input logic [CNT_BITS-1:0] cnt);
        logic [FILL_BITS+CNT_BITS-1:0] wide;
        wide = {{FILL_BITS{1'b0}}, cnt};
        return wide[FILL_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/fq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module fq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fq_seq.sv =====
// Command sequencer: ring pointers, count and the search walk over the RAM.
// Depends on fq_pkg; drives the ports of one fq_ram instance.
module fq_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fq_pkg::cmd_t                   in_cmd,
    input  logic [fq_pkg::DATA_BITS-1:0]   in_value,
    output logic                           res_valid,
    input  logic                           res_take,
    output fq_pkg::result_t                res,
    output logic                           ram_we,
    output logic [fq_pkg::ADDR_BITS-1:0]   ram_waddr,
    output logic [fq_pkg::WORD_BITS-1:0]   ram_wdata,
    output logic                           ram_re,
    output logic [fq_pkg::ADDR_BITS-1:0]   ram_raddr,
    input  logic [fq_pkg::WORD_BITS-1:0]   ram_rdata
);

    import fq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_POP_WAIT = 4'b0010,
        S_SEARCH   = 4'b0100,
        S_DONE     = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   head_reg, head_next;
    logic [ADDR_BITS-1:0]   tail_reg, tail_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [ADDR_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNT_BITS-1:0]    scan_left_reg, scan_left_next;
    logic [WORD_BITS-1:0]   key_reg, key_next;
    result_t                res_reg, res_next;
    logic                   hit;

    assign hit       = (ram_rdata == key_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        scan_left_next = scan_left_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = in_value[WORD_BITS-1:0];
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.status     = ST_OK;
                    res_next.data_out   = '0;
                    res_next.found      = 1'b0;
                    res_next.fill_count = fill_field(count_reg);
                    state_next          = S_DONE;
                    unique case (in_cmd)
                        CMD_PUSH:
                        begin
                            if (count_reg == CNT_BITS'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we              = 1'b1;
                                tail_next           = next_slot(tail_reg);
                                count_next          = count_reg + CNT_BITS'(1);
                                res_next.fill_count = fill_field(count_next);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re              = 1'b1;
                                head_next           = next_slot(head_reg);
                                count_next          = count_reg - CNT_BITS'(1);
                                res_next.fill_count = fill_field(count_next);
                                state_next          = S_POP_WAIT;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            key_next = in_value[WORD_BITS-1:0];
                            if (count_reg != '0)
                            begin
                                ram_re         = 1'b1;
                                scan_idx_next  = next_slot(head_reg);
                                scan_left_next = count_reg - CNT_BITS'(1);
                                state_next     = S_SEARCH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_next           = '0;
                            tail_next           = '0;
                            count_next          = '0;
                            res_next.fill_count = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                res_next.data_out = DATA_BITS'(ram_rdata);
                state_next        = S_DONE;
            end
            S_SEARCH:
            begin
                // Compare the word read last cycle; fetch the next one on a miss.
                if (hit || (scan_left_reg == '0))
                begin
                    res_next.found = hit;
                    state_next     = S_DONE;
                end
                else
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_idx_reg;
                    scan_idx_next  = next_slot(scan_idx_reg);
                    scan_left_next = scan_left_reg - CNT_BITS'(1);
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        scan_left_reg <= scan_left_next;
        key_reg       <= key_next;
        res_reg       <= res_next;
    end

endmodule

// ===== hw/rtl/fifo_queue_with_search_top.sv =====
// Top level of the searchable queue: sequencer, word RAM and output register.
// Depends on fq_pkg, fq_ram, fq_seq and fifo_queue_with_search_top_macros.svh.
//
// A first-in first-out queue of DEPTH words held as a ring in one synchronous
// RAM. Each request carries a command in s_axis_tuser (push, pop, search,
// clear) and a word in s_axis_tdata; each request yields exactly one result on
// the master side: a status, the popped word, a found flag and the count after
// the command. Push and clear write their result straight into the result
// register of the sequencer, a pop first waits for the RAM read, and a search
// walks the ring from the head one word per cycle through the single RAM read
// port, stopping at the first hit or after the last stored word; the result
// register then hands the result on to the output register. One request is
// worked on at a time; the next one is taken as soon as the previous result
// has moved into the output register, even while that result waits for
// m_axis_tready. A push into a full queue is refused with a full status, a
// pop from an empty queue gives an empty status with zero data, and clear only
// resets the pointers, so no clearing pass runs after reset. Words compare as
// raw bit patterns.
module fifo_queue_with_search_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] data_out, [64] found,
                                        // [69:65] fill_count, [71:70] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import fq_pkg::*;

    `include "fifo_queue_with_search_top_macros.svh"

    logic                   res_valid;
    logic                   res_take;
    result_t                res;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    // The output register takes a new result whenever it is empty or drains now.
    assign res_take = !out_valid_reg || m_axis_tready;

    fq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (cmd_t'(s_axis_tuser)),
        .in_value  (s_axis_tdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {2'b00, out_reg.fill_count, out_reg.found, out_reg.data_out};

    // A refused push reports a full queue.
    `FQ_ASSERT_IMP(a_full_count, out_valid_reg && (out_reg.status == ST_FULL), out_reg.fill_count == fill_field(CNT_BITS'(DEPTH)), "full status with a count below depth")

    // A refused pop carries neither data nor stored words.
    `FQ_ASSERT_IMP(a_empty_result, out_valid_reg && (out_reg.status == ST_EMPTY), (out_reg.data_out == '0) && (out_reg.fill_count == '0), "empty status with data or a nonzero count")

    // Only a search can report a hit, and a hit never comes from an empty queue.
    `FQ_ASSERT_IMP(a_found_ok, out_valid_reg && out_reg.found, (out_reg.status == ST_OK) && (out_reg.fill_count != '0) && (out_reg.data_out == '0), "found flag on a result that is no search hit")

    // Requests are worked on one at a time.
    `FQ_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while another is in progress")

endmodule

// ===== sim/fifo_queue_with_search_top_tb.sv =====
// Testbench for the searchable word queue: random and directed requests with idle gaps on both
// sides; every response is checked against a shadow queue held in a small tracker class.
// Depends on fq_pkg and the fifo_queue_with_search_top RTL.
module fifo_queue_with_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fq_pkg::*;

    localparam int RANDOM_REQUESTS = 450;
    localparam int STALL_LIMIT     = 2000;  // cycles with no transfer on either side
    localparam int MAX_IDLE        = 14;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] value
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // [63:0] data_out, [64] found, [69:65] fill_count, [71:70] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // Shadow copy of the queue. Each accepted request is applied to it at once and the
    // response it must produce is queued; responses leave the block in request order.
    class queue_tracker;
        logic [WORD_BITS-1:0] ring [DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned count;
        result_t     awaited [$];
        int          errors;
        int          responses;
        int          ops [4];
        int          full_refusals;
        int          empty_pops;
        int          search_hits;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            errors = 0;
            responses = 0;
            full_refusals = 0;
            empty_pops = 0;
            search_hits = 0;
            foreach (ops[i])
            begin
                ops[i] = 0;
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Word stored pos places behind the head; callers keep pos below count.
        function logic [63:0] word_at(int unsigned pos);
            return 64'(ring[(head + pos) % DEPTH]);
        endfunction

        function void note_request(cmd_t op, logic [63:0] value);
            result_t              r;
            logic [WORD_BITS-1:0] w;
            int unsigned          idx;
            w = value[WORD_BITS-1:0];   // bits above the word width are ignored
            r = '0;
            r.status = ST_OK;
            ops[op]++;
            case (op)
                CMD_PUSH:
                begin
                    if (count >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end
                    else
                    begin
                        ring[tail] = w;
                        tail = (tail + 1) % DEPTH;
                        count++;
                    end
                end
                CMD_POP:
                begin
                    if (count == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_pops++;
                    end
                    else
                    begin
                        r.data_out = DATA_BITS'(ring[head]);
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                end
                CMD_SEARCH:
                begin
                    idx = head;
                    for (int n = 0; n < count; n++)
                    begin
                        if (ring[idx] == w)
                        begin
                            r.found = 1'b1;
                            break;
                        end
                        idx = (idx + 1) % DEPTH;
                    end
                    if (r.found)
                    begin
                        search_hits++;
                    end
                end
                default:
                begin
                    // Clear only drops the pointers; old words stay but are unreachable.
                    head = 0;
                    tail = 0;
                    count = 0;
                end
            endcase
            r.fill_count = FILL_BITS'(count);
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(logic [71:0] data, logic [1:0] user);
            result_t r;
            if (awaited.size() == 0)
            begin
                report("response arrived with no request outstanding");
                return;
            end
            r = awaited.pop_front();
            responses++;
            if (user !== r.status)
            begin
                report($sformatf("response %0d status %0d, expected %0d",
                                 responses, user, r.status));
            end
            if (data[63:0] !== r.data_out)
            begin
                report($sformatf("response %0d data_out %h, expected %h",
                                 responses, data[63:0], r.data_out));
            end
            if (data[64] !== r.found)
            begin
                report($sformatf("response %0d found %b, expected %b",
                                 responses, data[64], r.found));
            end
            if (data[69:65] !== r.fill_count)
            begin
                report($sformatf("response %0d fill_count %0d, expected %0d",
                                 responses, data[69:65], r.fill_count));
            end
        endtask
    endclass

    queue_tracker tracker = new();

    logic [63:0] recent_pushes [$];  // recently pushed words, popped or not, for searches
    bit          send_calm;
    bit          recv_calm;
    int          quiet_cycles;

    fifo_queue_with_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Idle cycles before the next transfer; a calm stretch gives back-to-back transfers.
    function automatic int pick_idle(bit calm);
        if (calm)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Words mixing full-width random patterns with small values that repeat, so that
    // searches hit, and with the special double patterns: signed zeros, infinity, NaN.
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          bitpos;
        bitpos = $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            4:       w = 64'($urandom_range(0, 7));
            5:
            begin
                case ($urandom_range(0, 5))
                    0:       w = 64'h0000_0000_0000_0000;
                    1:       w = 64'hFFFF_FFFF_FFFF_FFFF;
                    2:       w = 64'h8000_0000_0000_0000;
                    3:       w = 64'h7FF0_0000_0000_0000;
                    4:       w = 64'h7FF8_0000_0000_0001;
                    default: w = 64'h0000_0000_0000_0001;
                endcase
            end
            6:       w = 64'h1 << bitpos;
            7:       w = ~(64'h1 << bitpos);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Searches mostly look for something that is stored now or was stored lately.
    function automatic logic [63:0] search_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5 && tracker.count > 0)
        begin
            return tracker.word_at($urandom_range(0, tracker.count - 1));
        end
        if (pick < 7 && recent_pushes.size() > 0)
        begin
            return recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
        end
        return random_word();
    endfunction

    // Presents one request and returns at the edge that accepts it. tvalid stays high
    // afterwards, so a following request with no gap goes out back to back.
    task automatic send_request(cmd_t op, logic [63:0] value);
        int gap;
        if ($urandom_range(0, 24) == 0)
        begin
            send_calm = !send_calm;
        end
        gap = pick_idle(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        tracker.note_request(op, value);
        if (op == CMD_PUSH)
        begin
            recent_pushes.push_back(value);
            if (recent_pushes.size() > 32)
            begin
                void'(recent_pushes.pop_front());
            end
        end
    endtask

    // Directed requests: empty queue, a fill up to the refusal, searches that must hit
    // the newest word or miss by one bit, signed zeros and NaN, and a clear.
    task automatic run_directed();
        logic [63:0] newest;
        send_request(CMD_POP, 64'h0);
        send_request(CMD_SEARCH, 64'h0);
        send_request(CMD_PUSH, 64'h0000_0000_0000_0000);
        send_request(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_PUSH, 64'h8000_0000_0000_0000);
        send_request(CMD_PUSH, 64'h7FF8_0000_0000_0000);
        newest = 64'h0;
        for (int i = 4; i < DEPTH; i++)
        begin
            newest = {$urandom, $urandom};
            send_request(CMD_PUSH, newest);
        end
        send_request(CMD_PUSH, 64'h0123_4567_89AB_CDEF);  // queue is full now
        send_request(CMD_SEARCH, newest);
        send_request(CMD_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(CMD_SEARCH, 64'h7FF8_0000_0000_0000);
        send_request(CMD_POP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_SEARCH, 64'h0000_0000_0000_0000);
        send_request(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_POP, 64'h0);
    endtask

    // Random requests in bursts; each burst leans toward filling, draining, searching or a
    // plain mix, so the queue spends time full, empty and wrapping around the ring.
    task automatic run_random(int total);
        int   sent;
        int   burst_left;
        int   lean;
        int   roll;
        int   push_pct;
        int   pop_pct;
        int   search_pct;
        cmd_t op;
        sent = 0;
        burst_left = 0;
        lean = 0;
        while (sent < total)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(4, 30);
                lean = $urandom_range(0, 3);
            end
            case (lean)
                0:       begin push_pct = 78; pop_pct = 8;  search_pct = 12; end
                1:       begin push_pct = 8;  pop_pct = 72; search_pct = 18; end
                2:       begin push_pct = 15; pop_pct = 15; search_pct = 68; end
                default: begin push_pct = 35; pop_pct = 30; search_pct = 32; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
            begin
                op = CMD_PUSH;
            end
            else if (roll < push_pct + pop_pct)
            begin
                op = CMD_POP;
            end
            else if (roll < push_pct + pop_pct + search_pct)
            begin
                op = CMD_SEARCH;
            end
            else
            begin
                op = CMD_CLEAR;
            end
            send_request(op, (op == CMD_SEARCH) ? search_word() : random_word());
            burst_left--;
            sent++;
        end
    endtask

    // Result side: a fresh stall before each response, held ready until it transfers.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        recv_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                recv_calm = !recv_calm;
            end
            stall = pick_idle(recv_calm);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Every response that transfers is checked against the oldest awaited one.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            tracker.check_response(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means the block hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, tracker.outstanding());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_PUSH;
        send_calm      = 1'b0;
        quiet_cycles   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_REQUESTS);
        s_axis_tvalid <= 1'b0;

        // Drain, then leave room for a late or extra response to show up.
        while (tracker.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 8) @(posedge clk);

        $display("Ran %0d pushes (%0d refused as full), %0d pops (%0d on empty), %0d searches (%0d hits), %0d clears.",
                 tracker.ops[CMD_PUSH], tracker.full_refusals, tracker.ops[CMD_POP],
                 tracker.empty_pops, tracker.ops[CMD_SEARCH], tracker.search_hits,
                 tracker.ops[CMD_CLEAR]);
        $display("Checked %0d responses, %0d mismatches.", tracker.responses, tracker.errors);
        if (tracker.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fq_pkg.sv
hw/rtl/fq_ram.sv
hw/rtl/fq_seq.sv
hw/rtl/fifo_queue_with_search_top.sv
sim/fifo_queue_with_search_top_tb.sv
